>>> hdl/dvrt_pkg.sv
// Package for the distance-vector route table: sizes, codes, word and
// route entry types, and the netmask helper. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dvrt_pkg;

  localparam int TABLE_DEPTH  = 64;
  localparam int IFACE_COUNT  = 4;
  localparam int RESULT_LIMIT = 64;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int LIM_W = $clog2(RESULT_LIMIT + 1);

  localparam logic [5:0] UNREACHABLE = 6'd16;

  localparam logic [1:0] FUNC_INSTALL = 2'd0;
  localparam logic [1:0] FUNC_APPLY   = 2'd1;
  localparam logic [1:0] FUNC_DUMP    = 2'd2;

  localparam logic [2:0] ST_ADDED      = 3'd0;
  localparam logic [2:0] ST_UPDATED    = 3'd1;
  localparam logic [2:0] ST_DELETED    = 3'd2;
  localparam logic [2:0] ST_IGNORED    = 3'd3;
  localparam logic [2:0] ST_FULL       = 3'd4;
  localparam logic [2:0] ST_DUMP_ENTRY = 3'd5;
  localparam logic [2:0] ST_DUMP_EMPTY = 3'd6;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] prefix;
    logic [31:0] net_mask;
    logic [4:0]  hop_metric;
    logic [1:0]  iface;
    logic [31:0] source_addr;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        changed;
    logic [31:0] out_prefix;
    logic [31:0] out_mask;
    logic [31:0] out_nexthop;
    logic [4:0]  out_metric;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic [31:0] prefix;
    logic [5:0]  length;
    logic [1:0]  iface;
    logic [31:0] nexthop;
    logic [4:0]  metric;
  } route_t;

  function automatic logic [31:0] mask_of_length(input logic [5:0] len);
    logic [31:0] m;
    if (len == 6'd0) begin
      m = 32'h0;
    end else if (len >= 6'd32) begin
      m = 32'hFFFF_FFFF;
    end else begin
      m = 32'hFFFF_FFFF << (6'd32 - len);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

>>> hdl/dvrt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module dvrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hdl/distance_vector_route_table.sv
// Top level of the distance-vector route table engine: sequencer, search,
// update and dump logic. Depends on dvrt_pkg and dvrt_ram.
//
//   channel   ports                      handshake
//   -------   ------------------------   ------------------------------------
//   command   cmd, start, busy           word taken when start && !busy
//   result    result, result_valid       word valid for one cycle, no stall
//
// Install and apply measure the prefix length in halving steps, search the
// table one entry per cycle through the route RAM read port, then decide
// and write; a delete then moves the last route into the freed slot.
// A dump gives one result word per emitted entry.
// Reset is synchronous and clears the route count; the RAM is not cleared.
// Results cannot be held off; busy stays high until the final word is out.
`timescale 1ns / 1ps
`default_nettype none

module distance_vector_route_table (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire dvrt_pkg::in_word_t  cmd,
  output logic                     result_valid,
  output dvrt_pkg::out_word_t      result
);

  localparam int RouteW = $bits(dvrt_pkg::route_t);
  localparam logic [2:0] StepLast = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE, S_LEN, S_SCAN, S_DECIDE, S_DEL_RD, S_DEL_WR, S_DUMP, S_DUMP_END
  } state_t;

  state_t state;
  dvrt_pkg::in_word_t cmd_r;
  logic [31:0] mask_r;
  logic [4:0]  zeros;
  logic [2:0]  step;
  logic [5:0]  len;
  logic [dvrt_pkg::CNT_W-1:0] count;
  logic [dvrt_pkg::CNT_W-1:0] rd_idx;
  logic                       chk_vld;
  logic [dvrt_pkg::IDX_W-1:0] chk_idx;
  logic                       hit_found;
  logic [dvrt_pkg::IDX_W-1:0] hit_idx;
  dvrt_pkg::route_t           hit;
  logic                       pend_vld;
  dvrt_pkg::out_word_t        pend;
  logic [dvrt_pkg::LIM_W-1:0] n_held;

  logic [RouteW-1:0] rd_raw;
  logic [RouteW-1:0] wr_raw;
  dvrt_pkg::route_t  rd_data;
  dvrt_pkg::route_t  wr_data;
  logic                       ram_we;
  logic [dvrt_pkg::IDX_W-1:0] ram_waddr;
  logic [dvrt_pkg::IDX_W-1:0] ram_raddr;
  logic [dvrt_pkg::CNT_W-1:0] cnt_m1;

  logic [5:0]  len_sh;
  logic [31:0] len_low;
  logic        len_skip;
  logic [4:0]  zeros_new;

  logic [5:0]  met;
  logic        full;
  logic        match;
  logic        dump_pass;
  logic        dec_we;
  logic [dvrt_pkg::IDX_W-1:0] dec_addr;
  dvrt_pkg::route_t           dec_data;
  logic [2:0]  dec_status;
  logic        dec_changed;
  logic        dec_add;
  logic        dec_del;
  dvrt_pkg::out_word_t        dump_word;

  assign busy = (state != S_IDLE);

  assign rd_data = dvrt_pkg::route_t'(rd_raw);
  assign wr_raw  = RouteW'(wr_data);
  assign cnt_m1  = count - dvrt_pkg::CNT_W'(1);

  dvrt_ram #(
    .WIDTH(RouteW),
    .DEPTH(dvrt_pkg::TABLE_DEPTH)
  ) u_route_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(wr_raw),
    .raddr(ram_raddr),
    .rdata(rd_raw)
  );

  // Trailing-zero count by halving steps of 16, 8, 4, 2 and 1 bits.
  assign len_sh    = 6'(6'd16 >> step);
  assign len_low   = ~(32'hFFFF_FFFF << len_sh);
  assign len_skip  = ((mask_r & len_low) == 32'h0);
  assign zeros_new = len_skip ? zeros + len_sh[4:0] : zeros;

  assign met   = {1'b0, cmd_r.hop_metric} + 6'd1;
  assign full  = (count >= dvrt_pkg::CNT_W'(dvrt_pkg::TABLE_DEPTH));
  assign match = chk_vld && (rd_data.prefix == cmd_r.prefix) && (rd_data.length == len);
  assign dump_pass = chk_vld && (rd_data.iface != cmd_r.iface);

  always_comb begin
    dump_word.status      = dvrt_pkg::ST_DUMP_ENTRY;
    dump_word.changed     = 1'b0;
    dump_word.out_prefix  = rd_data.prefix;
    dump_word.out_mask    = dvrt_pkg::mask_of_length(rd_data.length);
    dump_word.out_nexthop = rd_data.nexthop;
    dump_word.out_metric  = rd_data.metric;
    dump_word.last        = 1'b0;
  end

  always_comb begin
    dec_we      = 1'b0;
    dec_addr    = hit_idx;
    dec_data    = hit;
    dec_status  = dvrt_pkg::ST_IGNORED;
    dec_changed = 1'b0;
    dec_add     = 1'b0;
    dec_del     = 1'b0;
    if (cmd_r.func == dvrt_pkg::FUNC_INSTALL) begin
      dec_data.prefix  = cmd_r.prefix;
      dec_data.length  = len;
      dec_data.iface   = cmd_r.iface;
      dec_data.nexthop = 32'h0;
      dec_data.metric  = cmd_r.hop_metric;
      if (hit_found) begin
        dec_we      = 1'b1;
        dec_status  = dvrt_pkg::ST_UPDATED;
        dec_changed = 1'b1;
      end else if (full) begin
        dec_status = dvrt_pkg::ST_FULL;
      end else begin
        dec_we      = 1'b1;
        dec_addr    = count[dvrt_pkg::IDX_W-1:0];
        dec_add     = 1'b1;
        dec_status  = dvrt_pkg::ST_ADDED;
        dec_changed = 1'b1;
      end
    end else if (hit_found) begin
      if (hit.nexthop != 32'h0) begin
        if (hit.iface == cmd_r.iface) begin
          if (met > dvrt_pkg::UNREACHABLE) begin
            dec_del = 1'b1;
          end else begin
            dec_we           = 1'b1;
            dec_data.nexthop = cmd_r.source_addr;
            dec_data.metric  = met[4:0];
            dec_status       = dvrt_pkg::ST_UPDATED;
          end
        end else if (met < {1'b0, hit.metric}) begin
          dec_we           = 1'b1;
          dec_data.iface   = cmd_r.iface;
          dec_data.nexthop = cmd_r.source_addr;
          dec_data.metric  = met[4:0];
          dec_status       = dvrt_pkg::ST_UPDATED;
          dec_changed      = 1'b1;
        end
      end
    end else if (met <= dvrt_pkg::UNREACHABLE) begin
      if (full) begin
        dec_status = dvrt_pkg::ST_FULL;
      end else begin
        dec_we           = 1'b1;
        dec_addr         = count[dvrt_pkg::IDX_W-1:0];
        dec_data.prefix  = cmd_r.prefix;
        dec_data.length  = len;
        dec_data.iface   = cmd_r.iface;
        dec_data.nexthop = cmd_r.source_addr;
        dec_data.metric  = met[4:0];
        dec_add          = 1'b1;
        dec_status       = dvrt_pkg::ST_ADDED;
        dec_changed      = 1'b1;
      end
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = dec_addr;
    wr_data   = dec_data;
    ram_raddr = rd_idx[dvrt_pkg::IDX_W-1:0];
    case (state)
      S_DECIDE: begin
        ram_we = dec_we;
      end
      S_DEL_RD: begin
        ram_raddr = cnt_m1[dvrt_pkg::IDX_W-1:0];
      end
      S_DEL_WR: begin
        ram_we    = 1'b1;
        ram_waddr = hit_idx;
        wr_data   = rd_data;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      result_valid <= 1'b0;
      chk_vld      <= 1'b0;
      pend_vld     <= 1'b0;
      hit_found    <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            cmd_r <= cmd;
            if (cmd.func == dvrt_pkg::FUNC_DUMP) begin
              rd_idx   <= '0;
              chk_vld  <= 1'b0;
              pend_vld <= 1'b0;
              n_held   <= '0;
              state    <= S_DUMP;
            end else if ((cmd.func != dvrt_pkg::FUNC_INSTALL &&
                          cmd.func != dvrt_pkg::FUNC_APPLY) ||
                         int'(cmd.iface) >= dvrt_pkg::IFACE_COUNT) begin
              result       <= '{dvrt_pkg::ST_IGNORED, 1'b0, 32'h0, 32'h0, 32'h0,
                                5'h0, 1'b1};
              result_valid <= 1'b1;
            end else begin
              mask_r <= cmd.net_mask;
              zeros  <= '0;
              step   <= '0;
              state  <= S_LEN;
            end
          end
        end
        S_LEN: begin
          if (len_skip) begin
            mask_r <= mask_r >> len_sh;
          end
          zeros <= zeros_new;
          step  <= step + 3'd1;
          if (step == StepLast) begin
            len       <= (cmd_r.net_mask == 32'h0) ? 6'd0 : 6'd32 - {1'b0, zeros_new};
            rd_idx    <= '0;
            chk_vld   <= 1'b0;
            hit_found <= 1'b0;
            state     <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (match) begin
            hit_found <= 1'b1;
            hit_idx   <= chk_idx;
            hit       <= rd_data;
            chk_vld   <= 1'b0;
            state     <= S_DECIDE;
          end else if (rd_idx < count) begin
            chk_vld <= 1'b1;
            chk_idx <= rd_idx[dvrt_pkg::IDX_W-1:0];
            rd_idx  <= rd_idx + dvrt_pkg::CNT_W'(1);
          end else begin
            chk_vld <= 1'b0;
            state   <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (dec_del) begin
            state <= S_DEL_RD;
          end else begin
            if (dec_add) begin
              count <= count + dvrt_pkg::CNT_W'(1);
            end
            result       <= '{dec_status, dec_changed, 32'h0, 32'h0, 32'h0, 5'h0, 1'b1};
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        S_DEL_RD: begin
          state <= S_DEL_WR;
        end
        S_DEL_WR: begin
          count        <= cnt_m1;
          result       <= '{dvrt_pkg::ST_DELETED, 1'b1, 32'h0, 32'h0, 32'h0, 5'h0, 1'b1};
          result_valid <= 1'b1;
          state        <= S_IDLE;
        end
        S_DUMP: begin
          if (dump_pass) begin
            if (pend_vld) begin
              result       <= pend;
              result_valid <= 1'b1;
            end
            pend     <= dump_word;
            pend_vld <= 1'b1;
            n_held   <= n_held + dvrt_pkg::LIM_W'(1);
          end
          if (dump_pass && n_held == dvrt_pkg::LIM_W'(dvrt_pkg::RESULT_LIMIT - 1)) begin
            chk_vld <= 1'b0;
            state   <= S_DUMP_END;
          end else if (rd_idx < count) begin
            chk_vld <= 1'b1;
            chk_idx <= rd_idx[dvrt_pkg::IDX_W-1:0];
            rd_idx  <= rd_idx + dvrt_pkg::CNT_W'(1);
          end else begin
            chk_vld <= 1'b0;
            state   <= S_DUMP_END;
          end
        end
        S_DUMP_END: begin
          if (pend_vld) begin
            result <= '{pend.status, pend.changed, pend.out_prefix, pend.out_mask,
                        pend.out_nexthop, pend.out_metric, 1'b1};
          end else begin
            result <= '{dvrt_pkg::ST_DUMP_EMPTY, 1'b0, 32'h0, 32'h0, 32'h0, 5'h0, 1'b1};
          end
          result_valid <= 1'b1;
          pend_vld     <= 1'b0;
          state        <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The table never holds more routes than it has slots.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= dvrt_pkg::CNT_W'(dvrt_pkg::TABLE_DEPTH))
    else $error("route count exceeds table depth");

  // Only a dump produces words that are not the final word of a command.
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != dvrt_pkg::ST_DUMP_ENTRY |-> result.last)
    else $error("non-dump result without last");

  // The route count moves only in the decide and delete-write steps.
  a_count_steps: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $past(state) != S_DECIDE && $past(state) != S_DEL_WR
    |-> count == $past(count))
    else $error("route count changed outside an update step");

  // A command never finishes without delivering its final word.
  a_done_word: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $fell(busy) |-> result_valid && result.last)
    else $error("command ended without a final result word");

endmodule

`default_nettype wire
